// ===== sv/skin_matrix_blend_four_weights_macros.svh =====
// assertion macros for the skinning blend block
`ifndef SKIN_MATRIX_BLEND_FOUR_WEIGHTS_MACROS_SVH
`define SKIN_MATRIX_BLEND_FOUR_WEIGHTS_MACROS_SVH

`ifndef SYNTH
`define SMB4W_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smb4w check failed");
`define SMB4W_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smb4w check failed");
`else
`define SMB4W_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define SMB4W_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== sv/smb4w_pkg.sv =====
// shared constants and types for the skinning blend block
`default_nettype none

package smb4w_pkg;

   localparam int PAL_JOINTS = 128;
   localparam int FRAC_BITS  = 16;

   localparam int WEIGHT_W  = 25;
   localparam int DATA_W    = 32;
   localparam int ELEMS     = 16;
   localparam int ELEM_W    = 4;
   localparam int SLOT_W    = 7;
   localparam int JIU_W     = 8;
   localparam int CSR_IDX_W = 2;

   // joints_in_use after reset
   localparam int JIU_RESET = 128;

   localparam int JOINT_W   = (PAL_JOINTS > 1) ? $clog2(PAL_JOINTS) : 1;
   localparam int PAL_DEPTH = PAL_JOINTS * ELEMS;
   localparam int PAL_AW    = JOINT_W + ELEM_W;

   // integer part of a packed weight
   localparam int IDXV_W = WEIGHT_W - FRAC_BITS;
   localparam int LIM_W  = $clog2(PAL_JOINTS + 1);
   localparam int CMP_W  = ((IDXV_W > LIM_W) ? IDXV_W : LIM_W) + 1;

   // arithmetic widths
   localparam int SUM_W  = FRAC_BITS + 2;
   localparam int PROD_W = FRAC_BITS + 1 + DATA_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int DVD_W  = SUM_W + DATA_W;
   localparam int CNT_W  = $clog2(DATA_W);

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_BLEND = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_JOINTS_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPAIR_ZERO   = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADDR,
      ST_MUL,
      ST_ACC,
      ST_DIVSET,
      ST_DIV,
      ST_RESULT,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

// ===== sv/skin_matrix_blend_four_weights.sv =====
// top level: four-influence matrix palette blend with a shared mac and divider
//
//  channel | direction | transfer when          | carries
//  --------+-----------+------------------------+------------------------------------
//  req     | in        | req_valid & req_ready  | op, palette write or four weights
//  rsp     | out       | rsp_valid & rsp_ready  | one blended element per transfer
//  csr     | in        | csr_valid & csr_ready  | register index and write data
//
//  a load item is written to the palette as it is taken and leaves req_ready high
//  a blend item gives 16 results; each one runs a palette read and a mac per weight
//  (one palette read port, one multiplier), a divider setup, restoring division
//  of a 32-bit quotient and a step to register the result
//  a zero weight sum skips the mac and divider
//  synchronous reset resets the control registers and holds both ready lines low;
//  palette is not cleared
//  a stalled rsp holds the sequencer, req_ready stays low until the last element
`default_nettype none

module skin_matrix_blend_four_weights (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // input items
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_op,
   input  wire logic [smb4w_pkg::SLOT_W-1:0]          req_joint_slot,
   input  wire logic [smb4w_pkg::ELEM_W-1:0]          req_element_slot,
   input  wire logic signed [smb4w_pkg::DATA_W-1:0]   req_element_data,
   input  wire logic signed [smb4w_pkg::WEIGHT_W-1:0] req_packed_weight_a,
   input  wire logic signed [smb4w_pkg::WEIGHT_W-1:0] req_packed_weight_b,
   input  wire logic signed [smb4w_pkg::WEIGHT_W-1:0] req_packed_weight_c,
   input  wire logic signed [smb4w_pkg::WEIGHT_W-1:0] req_packed_weight_d,
   // results
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic      [smb4w_pkg::ELEM_W-1:0]          rsp_out_element,
   output logic signed [smb4w_pkg::DATA_W-1:0]        rsp_out_value,
   output logic                                       rsp_out_last,
   output logic                                       rsp_weights_ok,
   // configuration
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [smb4w_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [smb4w_pkg::JIU_W-1:0]           csr_data
);

`include "skin_matrix_blend_four_weights_macros.svh"

   localparam int JW  = smb4w_pkg::JOINT_W;
   localparam int FB  = smb4w_pkg::FRAC_BITS;
   localparam int SW  = smb4w_pkg::SUM_W;
   localparam int DW  = smb4w_pkg::DATA_W;
   localparam int CW  = smb4w_pkg::CMP_W;
   localparam int AW  = smb4w_pkg::ACC_W;
   localparam int PW  = smb4w_pkg::PROD_W;
   localparam int VW  = smb4w_pkg::DVD_W;
   localparam int KW  = smb4w_pkg::CNT_W;
   localparam int EW  = smb4w_pkg::ELEM_W;

   // control registers
   smb4w_pkg::state_type state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [smb4w_pkg::JIU_W-1:0] jiu_ff;
   logic                 repair_ff;

   // per-item working registers
   logic [JW-1:0]        idx_ff  [4];
   logic [JW-1:0]        idx_in  [4];
   logic [FB-1:0]        frac_ff [4];
   logic [FB-1:0]        frac_in [4];
   logic [SW-1:0]        sum_ff, sum_in;
   logic                 zero_ff, zero_in;
   logic [EW-1:0]        elem_ff, elem_in;
   logic [1:0]           k_ff, k_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic                 neg_ff, neg_in;
   logic [SW-1:0]        rem_ff, rem_in;
   logic [DW-1:0]        quo_ff, quo_in;
   logic [KW-1:0]        cnt_ff, cnt_in;
   logic signed [DW-1:0] val_ff, val_in;

   // palette port
   logic                                   pal_we;
   logic [smb4w_pkg::PAL_AW-1:0]           pal_waddr;
   logic                                   pal_re;
   logic [smb4w_pkg::PAL_AW-1:0]           pal_raddr;
   logic [DW-1:0]                          pal_rdata;

   // decode of the incoming weights
   logic signed [smb4w_pkg::WEIGHT_W-1:0]  pw [4];
   logic signed [smb4w_pkg::IDXV_W-1:0]    flr;
   logic [CW-1:0]                          flr_u;
   logic [CW-1:0]                          jiu_ext;
   logic [CW-1:0]                          lim;
   logic [CW-1:0]                          lim_m1;
   logic [CW-1:0]                          pick;
   logic [CW-1:0]                          slot_ext;
   logic [JW-1:0]                          idx_dec [4];
   logic [FB-1:0]                          frac_dec [4];
   logic [SW-1:0]                          sum_dec;

   // divider and result helpers
   logic [AW-1:0]                          mag;
   logic [VW-1:0]                          dvd;
   logic [SW:0]                            trial;
   logic                                   qbit;

   logic req_xfer;
   logic blend_xfer;
   logic rsp_xfer;

   assign req_xfer   = req_valid & req_ready;
   assign blend_xfer = req_xfer & (req_op == smb4w_pkg::OP_BLEND);
   assign rsp_xfer   = rsp_valid_ff & rsp_ready;

   assign req_ready = (state_ff == smb4w_pkg::ST_IDLE) & ~reset;
   assign csr_ready = ~reset;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_element = elem_ff;
   assign rsp_out_value   = val_ff;
   assign rsp_out_last    = (elem_ff == EW'(smb4w_pkg::ELEMS - 1));
   assign rsp_weights_ok  = ~zero_ff;

   // palette writes come straight from load transfers; slots past the palette drop
   assign slot_ext  = CW'(req_joint_slot);
   assign pal_we    = req_xfer & (req_op == smb4w_pkg::OP_LOAD) &
                      (slot_ext < CW'(smb4w_pkg::PAL_JOINTS));
   assign pal_waddr = {slot_ext[JW-1:0], req_element_slot};
   assign pal_re    = (state_ff == smb4w_pkg::ST_ADDR);
   assign pal_raddr = {idx_ff[k_ff], elem_ff};

   smb4w_ram #(
      .WIDTH (DW),
      .DEPTH (smb4w_pkg::PAL_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (pal_waddr),
      .wr_data (req_element_data),
      .rd_en   (pal_re),
      .rd_addr (pal_raddr),
      .rd_data (pal_rdata)
   );

   // weight decode: floor is the joint, clamped to 0..limit-1; fraction is the weight
   assign pw[0] = req_packed_weight_a;
   assign pw[1] = req_packed_weight_b;
   assign pw[2] = req_packed_weight_c;
   assign pw[3] = req_packed_weight_d;

   always_comb begin
      jiu_ext = CW'(jiu_ff);
      if (jiu_ext == '0) begin
         lim = CW'(1);
      end else if (jiu_ext > CW'(smb4w_pkg::PAL_JOINTS)) begin
         lim = CW'(smb4w_pkg::PAL_JOINTS);
      end else begin
         lim = jiu_ext;
      end
      lim_m1  = lim - CW'(1);
      sum_dec = '0;
      flr     = '0;
      flr_u   = '0;
      pick    = '0;
      for (int k = 0; k < 4; k++) begin
         frac_dec[k] = pw[k][FB-1:0];
         flr         = pw[k][smb4w_pkg::WEIGHT_W-1:FB];
         flr_u       = CW'(unsigned'(flr));
         if (flr < 0) begin
            pick = '0;
         end else if (flr_u > lim_m1) begin
            pick = lim_m1;
         end else begin
            pick = flr_u;
         end
         idx_dec[k] = pick[JW-1:0];
         sum_dec    = sum_dec + SW'(frac_dec[k]);
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smb4w_pkg::ST_IDLE: begin
            if (blend_xfer) begin
               state_in = smb4w_pkg::ST_ADDR;
            end
         end
         smb4w_pkg::ST_ADDR: begin
            state_in = smb4w_pkg::ST_MUL;
         end
         smb4w_pkg::ST_MUL: begin
            state_in = zero_ff ? smb4w_pkg::ST_OUT : smb4w_pkg::ST_ACC;
         end
         smb4w_pkg::ST_ACC: begin
            state_in = (k_ff == 2'd3) ? smb4w_pkg::ST_DIVSET : smb4w_pkg::ST_ADDR;
         end
         smb4w_pkg::ST_DIVSET: begin
            state_in = smb4w_pkg::ST_DIV;
         end
         smb4w_pkg::ST_DIV: begin
            if (cnt_ff == KW'(DW - 1)) begin
               state_in = smb4w_pkg::ST_RESULT;
            end
         end
         smb4w_pkg::ST_RESULT: begin
            state_in = smb4w_pkg::ST_OUT;
         end
         smb4w_pkg::ST_OUT: begin
            if (rsp_ready) begin
               state_in = rsp_out_last ? smb4w_pkg::ST_IDLE : smb4w_pkg::ST_ADDR;
            end
         end
         default: begin
            state_in = smb4w_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      idx_in       = idx_ff;
      frac_in      = frac_ff;
      sum_in       = sum_ff;
      zero_in      = zero_ff;
      elem_in      = elem_ff;
      k_in         = k_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff;
      mag          = acc_ff[AW-1] ? AW'(-acc_ff) : AW'(acc_ff);
      dvd          = mag[VW-1:0] + VW'(sum_ff >> 1);
      trial        = {rem_ff, quo_ff[DW-1]} - {1'b0, sum_ff};
      qbit         = ~trial[SW];
      case (state_ff)
         smb4w_pkg::ST_IDLE: begin
            if (blend_xfer) begin
               idx_in  = idx_dec;
               frac_in = frac_dec;
               sum_in  = sum_dec;
               zero_in = (sum_dec == '0);
               elem_in = '0;
               k_in    = '0;
            end
         end
         smb4w_pkg::ST_MUL: begin
            // palette word is back; form the product, and the zero-sum value when the sum is zero
            prod_in = $signed({1'b0, frac_ff[k_ff]}) * $signed(pal_rdata);
            if (zero_ff) begin
               val_in       = repair_ff ? $signed(pal_rdata) : '0;
               rsp_valid_in = 1'b1;
            end
         end
         smb4w_pkg::ST_ACC: begin
            acc_in = ((k_ff == 2'd0) ? '0 : acc_ff) + AW'(prod_ff);
            k_in   = k_ff + 2'd1;
         end
         smb4w_pkg::ST_DIVSET: begin
            // quotient fits in 32 bits since the blend is convex
            neg_in = acc_ff[AW-1];
            rem_in = dvd[VW-1:DW];
            quo_in = dvd[DW-1:0];
            cnt_in = '0;
         end
         smb4w_pkg::ST_DIV: begin
            if (qbit) begin
               rem_in = trial[SW-1:0];
            end else begin
               rem_in = {rem_ff[SW-2:0], quo_ff[DW-1]};
            end
            quo_in = {quo_ff[DW-2:0], qbit};
            cnt_in = cnt_ff + KW'(1);
         end
         smb4w_pkg::ST_RESULT: begin
            if (!neg_ff) begin
               val_in = (quo_ff > {1'b0, {(DW-1){1'b1}}}) ?
                        $signed({1'b0, {(DW-1){1'b1}}}) : $signed(quo_ff);
            end else begin
               val_in = (quo_ff > {1'b1, {(DW-1){1'b0}}}) ?
                        $signed({1'b1, {(DW-1){1'b0}}}) : $signed(-quo_ff);
            end
            rsp_valid_in = 1'b1;
         end
         smb4w_pkg::ST_OUT: begin
            if (rsp_xfer) begin
               rsp_valid_in = 1'b0;
               k_in         = '0;
               if (!rsp_out_last) begin
                  elem_in = elem_ff + EW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smb4w_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         jiu_ff       <= smb4w_pkg::JIU_W'(smb4w_pkg::JIU_RESET);
         repair_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == smb4w_pkg::CSR_JOINTS_IN_USE) begin
               jiu_ff <= csr_data;
            end else if (csr_index == smb4w_pkg::CSR_REPAIR_ZERO) begin
               repair_ff <= csr_data[0];
            end
         end
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      frac_ff <= frac_in;
      sum_ff  <= sum_in;
      zero_ff <= zero_in;
      elem_ff <= elem_in;
      k_ff    <= k_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      val_ff  <= val_in;
   end

   // checks
   `SMB4W_ASSERT_SAME(a_idle_no_rsp, clock, reset, req_ready, !rsp_valid)
   `SMB4W_ASSERT_NEXT(a_blend_busy, clock, reset, blend_xfer, !req_ready)
   `SMB4W_ASSERT_NEXT(a_last_frees, clock, reset, rsp_xfer && rsp_out_last, req_ready)
   `SMB4W_ASSERT_SAME(a_rsp_in_out, clock, reset, rsp_valid, state_ff == smb4w_pkg::ST_OUT)

endmodule

`default_nettype wire

// ===== sv/smb4w_ram.sv =====
// generic single write, single read ram with registered read data
`default_nettype none

module smb4w_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
